[design/piecewise_linear_curve_eval_defines.svh]
// Assertion macros used by the checker file of the curve evaluator.
`ifndef PIECEWISE_LINEAR_CURVE_EVAL_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_EVAL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLCV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLCV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/plcv_pkg.sv]
package plcv_pkg;

    localparam int unsigned FIELD_W        = 17;
    localparam int unsigned IDX_W          = 4;
    localparam int unsigned CNT_W          = 5;
    localparam int unsigned MAX_POINTS_DEF = 16;
    localparam int unsigned MIN_POINTS     = 2;
    localparam int unsigned DIV_NUM_W      = 36;
    localparam int unsigned DIV_DEN_W      = 18;

    localparam logic [FIELD_W-1:0] RESULT_MAX = '1;

    localparam logic MODE_EVAL  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_PREP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT
    } t_state;

endpackage

[design/plcv_ram.sv]
module plcv_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/plcv_div.sv]
module plcv_div #(
    parameter int unsigned NUM_W = plcv_pkg::DIV_NUM_W,
    parameter int unsigned DEN_W = plcv_pkg::DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int unsigned CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of the quotient register while quotient bits enter below.
    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = (shifted >= {1'b0, r_den});
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
            n_cnt  = CW'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], fits};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[design/piecewise_linear_curve_eval.sv]
// A breakpoint write is taken at once and gives no result. An evaluation with
// fewer than two points in use gives its result in the cycle after the request.
// Otherwise each breakpoint is read (ST_READ) and then compared (ST_CHECK), and an
// interpolation goes on through ST_PREP, ST_MUL and the divider. Throughput: one request
// per cycle for writes and short-table evaluations; else busy holds until the result is out.
// Reset (synchronous, active low) clears the sequencer and point_count; the table is kept.
module piecewise_linear_curve_eval #(
    parameter int unsigned MAX_POINTS = plcv_pkg::MAX_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_mode,
    input  logic [plcv_pkg::FIELD_W-1:0] i_value,
    input  logic [plcv_pkg::IDX_W-1:0]   i_index,
    input  logic [plcv_pkg::FIELD_W-1:0] i_point_x,
    input  logic [plcv_pkg::FIELD_W-1:0] i_point_y,
    output logic                         o_done,
    output logic [plcv_pkg::FIELD_W-1:0] o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [plcv_pkg::CNT_W-1:0]   i_cfg_point_count
);

    localparam int unsigned FW = plcv_pkg::FIELD_W;
    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned NW = $clog2(MAX_POINTS + 1);
    // Width that holds both the 5-bit point count and the table depth.
    localparam int unsigned CW = (NW > plcv_pkg::CNT_W) ? NW : plcv_pkg::CNT_W;
    // Width that holds both the 4-bit slot index and the table depth.
    localparam int unsigned IW = (NW > plcv_pkg::IDX_W) ? NW : plcv_pkg::IDX_W;
    localparam int unsigned NUM_W = plcv_pkg::DIV_NUM_W;
    localparam int unsigned DEN_W = plcv_pkg::DIV_DEN_W;

    plcv_pkg::t_state r_state, n_state;

    logic [plcv_pkg::CNT_W-1:0] r_count;
    logic [FW-1:0]   r_value, n_value;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_last, n_last;
    logic [FW-1:0]   r_x0, n_x0, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1;
    logic [FW-1:0]   r_ady, n_ady, r_adv, n_adv, r_aden, n_aden;
    logic            r_neg, n_neg;
    logic [2*FW-1:0] r_prod, n_prod;
    logic [FW-1:0]   r_res, n_res;
    logic            r_vld, n_vld;

    logic              accept;
    logic              wr_en;
    logic              rd_en;
    logic [2*FW-1:0]   rd_data;
    logic [FW-1:0]     rd_x, rd_y;
    logic [CW-1:0]     cnt_eff;
    logic [FW:0]       dy, dv, den;
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic [NUM_W-1:0]  y0_wide;
    logic [NUM_W-1:0]  neg_diff;
    logic [NUM_W:0]    pos_sum;
    logic [FW-1:0]     sat_res;

    assign accept      = start && !busy;
    assign busy        = (r_state != plcv_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_vld;
    assign o_result    = r_res;

    // A write to a slot beyond the table depth is dropped.
    assign wr_en = accept && (i_mode == plcv_pkg::MODE_WRITE)
                   && (IW'(i_index) < IW'(MAX_POINTS));

    // Table entries hold x in the upper half and y in the lower half.
    plcv_ram #(
        .WIDTH (2 * FW),
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_index)),
        .i_wdata ({i_point_x, i_point_y}),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign rd_x = rd_data[2*FW-1:FW];
    assign rd_y = rd_data[FW-1:0];

    // A point count beyond the table depth is treated as the full table.
    assign cnt_eff = (CW'(r_count) > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(r_count);

    // Segment differences, taken as signed values one bit wider than the fields.
    assign dy  = {1'b0, r_y1} - {1'b0, r_y0};
    assign dv  = {1'b0, r_value} - {1'b0, r_x0};
    assign den = {1'b0, r_x1} - {1'b0, r_x0};

    // Rounding to nearest with ties away from zero: (2|num| + |den|) / (2|den|).
    assign div_num = {1'b0, r_prod, 1'b0} + NUM_W'(r_aden);
    assign div_den = {r_aden, 1'b0};

    plcv_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Apply the signed quotient to y0 and clamp to the field's range.
    assign y0_wide  = NUM_W'(r_y0);
    assign neg_diff = y0_wide - div_quot;
    assign pos_sum  = {1'b0, div_quot} + (NUM_W + 1)'(r_y0);

    always_comb begin
        if (r_neg) begin
            sat_res = (div_quot > y0_wide) ? '0 : neg_diff[FW-1:0];
        end else begin
            sat_res = (pos_sum > (NUM_W + 1)'(plcv_pkg::RESULT_MAX))
                      ? plcv_pkg::RESULT_MAX : pos_sum[FW-1:0];
        end
    end

    // Sequencer: the search walks the table one entry at a time, through ST_READ (address)
    // and then ST_CHECK (registered read data), keeping the previous entry as the left end
    // of the segment. The first entry after entry 0 that is not below the input closes it.
    always_comb begin
        n_state   = r_state;
        n_value   = r_value;
        n_idx     = r_idx;
        n_last    = r_last;
        n_x0      = r_x0;
        n_y0      = r_y0;
        n_x1      = r_x1;
        n_y1      = r_y1;
        n_ady     = r_ady;
        n_adv     = r_adv;
        n_aden    = r_aden;
        n_neg     = r_neg;
        n_prod    = r_prod;
        n_res     = r_res;
        n_vld     = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            plcv_pkg::ST_IDLE: begin
                if (accept && (i_mode == plcv_pkg::MODE_EVAL)) begin
                    n_value = i_value;
                    n_idx   = '0;
                    n_last  = AW'(cnt_eff - CW'(1));
                    if (cnt_eff < CW'(plcv_pkg::MIN_POINTS)) begin
                        // Too few points: the input passes through.
                        n_res = i_value;
                        n_vld = 1'b1;
                    end else begin
                        n_state = plcv_pkg::ST_READ;
                    end
                end
            end
            plcv_pkg::ST_READ: begin
                rd_en   = 1'b1;
                n_state = plcv_pkg::ST_CHECK;
            end
            plcv_pkg::ST_CHECK: begin
                if (r_idx == '0) begin
                    n_x0    = rd_x;
                    n_y0    = rd_y;
                    n_idx   = AW'(1);
                    n_state = plcv_pkg::ST_READ;
                end else if (r_value <= rd_x) begin
                    n_x1    = rd_x;
                    n_y1    = rd_y;
                    n_state = plcv_pkg::ST_PREP;
                end else if (r_idx == r_last) begin
                    // Beyond the last point: the input passes through.
                    n_res   = r_value;
                    n_vld   = 1'b1;
                    n_state = plcv_pkg::ST_IDLE;
                end else begin
                    n_x0    = rd_x;
                    n_y0    = rd_y;
                    n_idx   = r_idx + AW'(1);
                    n_state = plcv_pkg::ST_READ;
                end
            end
            plcv_pkg::ST_PREP: begin
                if (den == '0) begin
                    // Zero-width segment: the earlier point's y stands.
                    n_res   = r_y0;
                    n_vld   = 1'b1;
                    n_state = plcv_pkg::ST_IDLE;
                end else begin
                    n_ady   = dy[FW]  ? FW'(-dy)  : dy[FW-1:0];
                    n_adv   = dv[FW]  ? FW'(-dv)  : dv[FW-1:0];
                    n_aden  = den[FW] ? FW'(-den) : den[FW-1:0];
                    n_neg   = dy[FW] ^ dv[FW] ^ den[FW];
                    n_state = plcv_pkg::ST_MUL;
                end
            end
            plcv_pkg::ST_MUL: begin
                n_prod  = {{FW{1'b0}}, r_ady} * {{FW{1'b0}}, r_adv};
                n_state = plcv_pkg::ST_DIV_GO;
            end
            plcv_pkg::ST_DIV_GO: begin
                div_start = 1'b1;
                n_state   = plcv_pkg::ST_DIV_WAIT;
            end
            plcv_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_res   = sat_res;
                    n_vld   = 1'b1;
                    n_state = plcv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = plcv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plcv_pkg::ST_IDLE;
            r_vld   <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_point_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_idx   <= n_idx;
        r_last  <= n_last;
        r_x0    <= n_x0;
        r_y0    <= n_y0;
        r_x1    <= n_x1;
        r_y1    <= n_y1;
        r_ady   <= n_ady;
        r_adv   <= n_adv;
        r_aden  <= n_aden;
        r_neg   <= n_neg;
        r_prod  <= n_prod;
        r_res   <= n_res;
    end

endmodule

[design/plcv_chk.sv]
`include "piecewise_linear_curve_eval_defines.svh"

module plcv_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_mode,
    input logic o_done
);

    // A breakpoint write finishes at once and gives no result.
    `PLCV_ASSERT_NEXT(a_write_quiet, i_clk, i_rst_n, start && !busy && i_mode, !busy && !o_done, "write request produced a result or held busy")

    // An evaluation either completes at once or keeps the block busy.
    `PLCV_ASSERT_NEXT(a_eval_progress, i_clk, i_rst_n, start && !busy && !i_mode, busy || o_done, "evaluation request was dropped")

    // Every evaluation that held the block busy ends with a result.
    `PLCV_ASSERT_SAME(a_busy_end_result, i_clk, i_rst_n, $fell(busy), o_done, "busy ended without a result")

    // No result appears while a request is still in work.
    `PLCV_ASSERT_SAME(a_no_result_busy, i_clk, i_rst_n, busy, !o_done, "result strobe while busy")

endmodule

bind piecewise_linear_curve_eval plcv_chk u_plcv_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_mode  (i_mode),
    .o_done  (o_done)
);

[bench/tb_piecewise_linear_curve_eval.sv]
`timescale 1ns / 1ps

module tb_piecewise_linear_curve_eval;

    // The breakpoint table size of the instance under test.
    localparam int unsigned SLOTS = plcv_pkg::MAX_POINTS_DEF;

    localparam int unsigned FW = plcv_pkg::FIELD_W;
    localparam int unsigned IW = plcv_pkg::IDX_W;
    localparam int unsigned CW = plcv_pkg::CNT_W;

    // The longest evaluation is a full search over the table plus the divider.
    // A few spare cycles are added so that a trailing write is surely retired.
    localparam int unsigned SETTLE_CYCLES = 2 * SLOTS + 40 + 8;

    // The least number of random requests sent after the directed tests.
    localparam int unsigned RANDOM_ITEMS = 1350;

    // The limit lies far above the slowest correct run: about 1400 requests, each with its
    // work and a sender gap, plus about 40 settle pauses.
    localparam int unsigned CYCLE_LIMIT = 1000000;

    // Only the first few failures are printed in full. Later ones are counted.
    localparam int unsigned REPORT_LIMIT = 10;

    // One pending evaluation: the point that was requested and its curve value.
    typedef struct packed {
        logic [FW-1:0] point;
        logic [FW-1:0] result;
    } t_curve_sample;

    // Every input is driven to a known value from time zero.
    logic          i_clk             = 1'b0;
    logic          i_rst_n           = 1'b0;
    logic          start             = 1'b0;
    logic          i_mode            = plcv_pkg::MODE_EVAL;
    logic [FW-1:0] i_value           = '0;
    logic [IW-1:0] i_index           = '0;
    logic [FW-1:0] i_point_x         = '0;
    logic [FW-1:0] i_point_y         = '0;
    logic          i_cfg_valid       = 1'b0;
    logic [CW-1:0] i_cfg_point_count = '0;
    logic          busy;
    logic          o_done;
    logic [FW-1:0] o_result;
    logic          o_cfg_ready;

    // The bench keeps its own copy of the breakpoint table and of the point count.
    // The written flags keep every evaluation away from slots that hold no data yet.
    logic [FW-1:0] curve_x [SLOTS];
    logic [FW-1:0] curve_y [SLOTS];
    logic          slot_written [SLOTS];
    logic [CW-1:0] points_in_use = '0;

    // Curve values that are still on their way out of the block, oldest first.
    t_curve_sample pending_values [$];

    int unsigned   fail_count    = 0;
    int unsigned   cycle_count   = 0;
    int unsigned   requests_sent = 0;
    int unsigned   burst_left    = 0;
    logic          start_high    = 1'b0;

    piecewise_linear_curve_eval #(
        .MAX_POINTS(SLOTS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_value          (i_value),
        .i_index          (i_index),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .o_done           (o_done),
        .o_result         (o_result),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_point_count(i_cfg_point_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            curve_x[s]      = '0;
            curve_y[s]      = '0;
            slot_written[s] = 1'b0;
        end
    end

    // A hung block must not hang the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("piecewise_linear_curve_eval regression: fail");
            $finish;
        end
    end

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, what);
        end
    endfunction

    // Curve value at one point, from the bench's copy of the table. The search
    // starts at the second breakpoint; the first one is never compared. Products
    // and quotients are kept in 64 bits, so no step of the arithmetic can overflow.
    function automatic logic [FW-1:0] predict_curve_value(input logic [FW-1:0] point);
        int unsigned       active;
        longint            x0;
        longint            y0;
        longint            x1;
        longint            y1;
        longint            den;
        longint            num;
        longint            quot;
        longint            level;
        longint unsigned   mag_num;
        longint unsigned   mag_den;
        active = 32'(points_in_use);
        // A count above the table size uses the whole table.
        if (active > SLOTS) begin
            active = SLOTS;
        end
        // With fewer than two breakpoints the point passes through.
        if (active < plcv_pkg::MIN_POINTS) begin
            return point;
        end
        for (int i = 1; i < active; i++) begin
            if (point <= curve_x[i]) begin
                x0  = longint'(curve_x[i-1]);
                y0  = longint'(curve_y[i-1]);
                x1  = longint'(curve_x[i]);
                y1  = longint'(curve_y[i]);
                den = x1 - x0;
                // A segment of zero width yields the ordinate of its first end.
                if (den == 0) begin
                    return curve_y[i-1];
                end
                // An unordered segment (x1 below x0) goes through the same signed
                // formula. The quotient is rounded to nearest, ties away from zero.
                num     = (y1 - y0) * (longint'(point) - x0);
                mag_num = (num < 0) ? -num : num;
                mag_den = (den < 0) ? -den : den;
                quot    = longint'((2 * mag_num + mag_den) / (2 * mag_den));
                level   = ((num < 0) != (den < 0)) ? y0 - quot : y0 + quot;
                if (level < 0) begin
                    level = 0;
                end
                if (level > longint'(plcv_pkg::RESULT_MAX)) begin
                    level = longint'(plcv_pkg::RESULT_MAX);
                end
                return level[FW-1:0];
            end
        end
        // Past the last breakpoint the point passes through.
        return point;
    endfunction

    // Book one accepted request: a write updates the table copy, an evaluation
    // adds its predicted curve value to the pending list.
    function automatic void book_request(input logic          mode,
                                         input logic [FW-1:0] point,
                                         input logic [IW-1:0] slot,
                                         input logic [FW-1:0] knot_x,
                                         input logic [FW-1:0] knot_y);
        t_curve_sample entry;
        requests_sent++;
        if (mode == plcv_pkg::MODE_WRITE) begin
            curve_x[slot]      = knot_x;
            curve_y[slot]      = knot_y;
            slot_written[slot] = 1'b1;
        end else begin
            entry.point  = point;
            entry.result = predict_curve_value(point);
            pending_values.push_back(entry);
        end
    endfunction

    // Drop start if it is high. Start is assigned at most once per time step.
    task automatic release_start();
        if (start_high) begin
            start      <= 1'b0;
            start_high  = 1'b0;
        end
    endtask

    // The sender runs in bursts. At the end of each burst start drops for a gap,
    // which may land on any phase of the work in progress. Now and then a long
    // burst runs with no gap at all.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            release_start();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 120);
            end else begin
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    // Send one request and hold it until the block takes it, that is, until a
    // rising edge at which start is high and busy is low. The handshake signals
    // are read right after the edge, so they still hold their values from before it.
    task automatic send_request(input logic          mode,
                                input logic [FW-1:0] point,
                                input logic [IW-1:0] slot,
                                input logic [FW-1:0] knot_x,
                                input logic [FW-1:0] knot_y);
        start      <= 1'b1;
        i_mode     <= mode;
        i_value    <= point;
        i_index    <= slot;
        i_point_x  <= knot_x;
        i_point_y  <= knot_y;
        start_high  = 1'b1;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        book_request(mode, point, slot, knot_x, knot_y);
        pace_sender();
    endtask

    // The evaluation requests of the directed tests carry fixed filler in the
    // point fields. The write requests carry a zero evaluation point.
    task automatic send_eval(input logic [FW-1:0] point);
        send_request(plcv_pkg::MODE_EVAL, point, '0, '0, '0);
    endtask

    task automatic send_knot(input logic [IW-1:0] slot,
                             input logic [FW-1:0] knot_x,
                             input logic [FW-1:0] knot_y);
        send_request(plcv_pkg::MODE_WRITE, '0, slot, knot_x, knot_y);
    endtask

    // Bring the block to idle. A write request gives no result, and the block takes it
    // at once. Wait for the last curve value and for busy to drop, then wait out the longest
    // latency on top of that before the point count may change.
    task automatic settle_block();
        release_start();
        while (pending_values.size() != 0) begin
            @(posedge i_clk);
        end
        while (busy) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the point count through its own valid/ready channel.
    task automatic write_point_count(input logic [CW-1:0] count);
        i_cfg_valid       <= 1'b1;
        i_cfg_point_count <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        points_in_use  = count;
        i_cfg_valid   <= 1'b0;
    endtask

    // Check each curve value in the cycle its strobe marks it, against the oldest
    // prediction still pending.
    always @(posedge i_clk) begin
        t_curve_sample want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_values.size() == 0) begin
                note_failure($sformatf("curve value %0d came with no request pending",
                                       o_result));
            end else begin
                want = pending_values.pop_front();
                if (o_result !== want.result) begin
                    note_failure($sformatf("curve value at %0d: expected %0d, got %0d",
                                           want.point, want.result, o_result));
                end
            end
        end
    end

    // With zero or one breakpoint in use the point passes straight through,
    // across the whole input range.
    task automatic test_short_table();
        send_knot(IW'(0), 17'd16384, 17'd16384);
        send_knot(IW'(1), 17'd49152, 17'd65536);
        settle_block();
        write_point_count(CW'(0));
        send_eval('0);
        send_eval(plcv_pkg::RESULT_MAX);
        settle_block();
        write_point_count(CW'(1));
        send_eval(17'd70000);
    endtask

    // A two point curve: both ends, the middle, rounding ties on either side of
    // the first point, extrapolation below the first point that clips at zero,
    // and points past the last breakpoint that pass through.
    task automatic test_interpolation();
        settle_block();
        write_point_count(CW'(2));
        send_eval(17'd16384);
        send_eval(17'd32768);
        send_eval(17'd49152);
        send_eval(17'd16385);
        send_eval(17'd16383);
        send_eval('0);
        send_eval(17'd49153);
        send_eval(plcv_pkg::RESULT_MAX);
    endtask

    // The first segment reshaped in place: zero width, then so steep that the
    // extrapolated value clips at the top, then unordered with x falling.
    task automatic test_special_segments();
        send_knot(IW'(0), 17'd49152, 17'd1234);
        send_eval(17'd1000);
        send_eval(17'd49152);
        send_knot(IW'(0), 17'd60000, 17'd65536);
        send_knot(IW'(1), 17'd60001, 17'd0);
        send_eval('0);
        send_knot(IW'(1), 17'd32768, 17'd32768);
        send_eval(17'd16384);
        send_eval(17'd32768);
    endtask

    // Load a well-formed curve into slots 0 up to active-1, with x rising. Some
    // strides are zero to make zero-width segments, and some curves swing their
    // ordinates between the extremes so that extrapolation clips.
    task automatic load_sorted_curve(input int unsigned active);
        int unsigned   x_walk;
        int unsigned   stride_max;
        int unsigned   stride;
        logic          zigzag;
        logic [FW-1:0] knot_y;
        x_walk     = $urandom_range(0, 40000);
        stride_max = (65536 - x_walk) / ((active > 1) ? active - 1 : 1);
        zigzag     = ($urandom_range(0, 5) == 0);
        for (int s = 0; s < active; s++) begin
            if (zigzag) begin
                knot_y = (s % 2 == 0) ? 17'd65536 : 17'd0;
            end else begin
                knot_y = FW'($urandom_range(0, 65536));
            end
            send_request(plcv_pkg::MODE_WRITE, FW'($urandom_range(0, plcv_pkg::RESULT_MAX)),
                         IW'(s), FW'(x_walk), knot_y);
            if ($urandom_range(0, 9) == 0) begin
                stride = 0;
            end else begin
                stride = $urandom_range(1, 2 * stride_max + 1);
            end
            x_walk = (x_walk + stride > 65536) ? 65536 : x_walk + stride;
        end
    endtask

    // Any slot below the active count that holds no data yet gets a random point.
    task automatic fill_missing_slots(input int unsigned active);
        for (int s = 0; s < active; s++) begin
            if (!slot_written[s]) begin
                send_request(plcv_pkg::MODE_WRITE,
                             FW'($urandom_range(0, plcv_pkg::RESULT_MAX)), IW'(s),
                             FW'($urandom_range(0, 65536)), FW'($urandom_range(0, 65536)));
            end
        end
    endtask

    // Evaluation points aim at the breakpoints and their neighbors as well as at
    // the whole input range and its extremes.
    function automatic logic [FW-1:0] pick_eval_point(input int unsigned active);
        int unsigned   pick;
        int unsigned   slot;
        logic [FW-1:0] knot_x;
        pick = $urandom_range(0, 99);
        slot = (active > 0) ? $urandom_range(0, active - 1) : 0;
        knot_x = curve_x[slot];
        if (pick < 35) begin
            return FW'($urandom_range(0, plcv_pkg::RESULT_MAX));
        end else if (pick < 65) begin
            return FW'($urandom_range(0, 65536));
        end else if (pick < 90) begin
            case ($urandom_range(0, 2))
                0:       return knot_x - FW'(1);
                1:       return knot_x;
                default: return knot_x + FW'(1);
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return 17'd1;
                2:       return 17'd65536;
                default: return plcv_pkg::RESULT_MAX;
            endcase
        end
    endfunction

    // Random phases. Each phase starts from idle with a new point count: first
    // the full table, counts above the table size, zero, one, two and seventeen,
    // then random ones. Most phases load a well-formed curve and then mix
    // evaluations with a few writes, some with arbitrary 17-bit values that break
    // the ordering of the table.
    task automatic test_random_curves();
        int unsigned count_plan [6] = '{16, 31, 0, 1, 2, 17};
        int unsigned stop_at;
        int unsigned phase;
        int unsigned count;
        int unsigned active;
        int unsigned pick;
        stop_at = requests_sent + RANDOM_ITEMS;
        phase   = 0;
        while (requests_sent < stop_at) begin
            settle_block();
            if (phase < 6) begin
                count = count_plan[phase];
            end else if ($urandom_range(0, 9) == 0) begin
                count = $urandom_range(0, 31);
            end else begin
                count = $urandom_range(2, 16);
            end
            write_point_count(CW'(count));
            active = (count > SLOTS) ? SLOTS : count;
            if ($urandom_range(0, 4) != 0) begin
                load_sorted_curve(active);
            end
            fill_missing_slots(active);
            repeat ($urandom_range(20, 80)) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    send_request(plcv_pkg::MODE_WRITE,
                                 FW'($urandom_range(0, plcv_pkg::RESULT_MAX)),
                                 IW'($urandom_range(0, SLOTS - 1)),
                                 FW'($urandom_range(0, plcv_pkg::RESULT_MAX)),
                                 FW'($urandom_range(0, plcv_pkg::RESULT_MAX)));
                end else if (pick < 12) begin
                    send_request(plcv_pkg::MODE_WRITE,
                                 FW'($urandom_range(0, plcv_pkg::RESULT_MAX)),
                                 IW'($urandom_range(0, SLOTS - 1)),
                                 FW'($urandom_range(0, 65536)),
                                 FW'($urandom_range(0, 65536)));
                end else begin
                    send_request(plcv_pkg::MODE_EVAL, pick_eval_point(active),
                                 IW'($urandom_range(0, SLOTS - 1)),
                                 FW'($urandom_range(0, plcv_pkg::RESULT_MAX)),
                                 FW'($urandom_range(0, plcv_pkg::RESULT_MAX)));
                end
            end
            phase++;
        end
    endtask

    // Reset is held at the start and released once. The tests then run in
    // turn, and the run ends once the block has gone quiet.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_table();
        test_interpolation();
        test_special_segments();
        test_random_curves();
        settle_block();
        if (fail_count == 0) begin
            $display("piecewise_linear_curve_eval regression: pass");
        end else begin
            $display("piecewise_linear_curve_eval regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/plcv_pkg.sv
design/plcv_ram.sv
design/plcv_div.sv
design/piecewise_linear_curve_eval.sv
design/plcv_chk.sv
bench/tb_piecewise_linear_curve_eval.sv
